FILE: rtl/mccc_pkg.sv
// package: payload types, register indexes and limits for the correlation criterion core
`default_nettype none
package mccc_pkg;

	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 16;
	localparam int CW           = 9;
	localparam int MAG_LIMIT    = 4194303;
	localparam int TIE_LIMIT    = 127;
	localparam int WEIGHT_LIMIT = 31;

	localparam logic [6:0] ROWS_RESET = 7'd64;
	localparam logic [4:0] COLS_RESET = 5'd16;
	localparam logic [7:0] LVL_RESET  = 8'd64;

	typedef enum logic [1:0] {
		REG_ROWS_IN_USE  = 2'd0,
		REG_COLS_IN_USE  = 2'd1,
		REG_LEVEL_COUNT  = 2'd2
	} mccc_reg_t;

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_EVAL = 1'b1
	} mccc_req_t;

	typedef struct packed {
		logic       req_type;
		logic [5:0] row;
		logic [3:0] col;
		logic [7:0] level;
	} mccc_in_t;

	typedef struct packed {
		logic [3:0]  column_index;
		logic [4:0]  column_weight;
		logic [21:0] max_abs_product;
		logic [6:0]  tie_count;
		logic        last;
	} mccc_out_t;

endpackage
`default_nettype wire

FILE: rtl/max_column_correlation_criterion_core.sv
// top level: maximum absolute column correlation criterion over a stored level design
// a load item is written into the design store; an evaluate item compares all P column pairs,
// P = cols*(cols-1)/2, rows and cols being the clamped register values
// the single multiply-accumulate unit walks one row per cycle for each column pair,
// then the pair store is read back pair by pair, in a read and a check state, to count weights
// no new item is taken until the last result of an evaluate has been delivered
// arst_n clears the sequencer, registers and flags; the design store is undefined until loaded
`default_nettype none
module max_column_correlation_criterion_core
	import mccc_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire mccc_in_t   in_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output mccc_out_t       out_data,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_idx,
	input  wire logic [7:0] cfg_wdata
);

	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int K_W    = $clog2(MAX_ROWS);
	localparam int NR_W   = $clog2(MAX_ROWS + 1);
	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int NC_W   = $clog2(MAX_COLS + 1);
	localparam int PAIRS  = MAX_COLS * (MAX_COLS - 1) / 2;
	localparam int SLOT_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
	localparam int ACC_W  = 2 * CW + $clog2(MAX_ROWS) + 1;
	localparam int MW     = (ACC_W > 23) ? ACC_W : 23;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_ISSUE = 7'b0000010,
		S_DRAIN = 7'b0000100,
		S_CMP   = 7'b0001000,
		S_WRD   = 7'b0010000,
		S_WCHK  = 7'b0100000,
		S_EMIT  = 7'b1000000
	} state_t;

	state_t state_q;

	logic [6:0] cfg_rows_q;
	logic [4:0] cfg_cols_q;
	logic [7:0] cfg_lvl_q;

	logic [NR_W-1:0]  nrows_q, nrows_c;
	logic [NC_W-1:0]  ncols_q, ncols_c;
	logic [K_W-1:0]   k_q;
	logic [COL_W-1:0] i_q, j_q, ocol_q;
	logic [SLOT_W-1:0] slot_q;

	logic signed [CW-1:0]     dmem [DEPTH];
	logic signed [CW-1:0]     rd_a_s1, rd_b_s1;
	logic                     v_s1, v_s2;
	logic signed [2*CW-1:0]   prod_s2;
	logic signed [ACC_W-1:0]  acc_q;

	logic [21:0] mag_mem [PAIRS];
	logic [21:0] mag_rd_q;
	logic [21:0] max_q;
	logic [6:0]  ties_q;
	logic [4:0]  weight_q [MAX_COLS];

	logic              in_acc, load_we;
	logic [7:0]        lc, lv;
	logic [9:0]        cval;
	logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
	logic [ACC_W-1:0]  abs_v;
	logic [21:0]       mag;
	logic              last_pair, col_wrap, hit, last_k, last_col;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_rows_q <= ROWS_RESET;
			cfg_cols_q <= COLS_RESET;
			cfg_lvl_q  <= LVL_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ROWS_IN_USE: cfg_rows_q <= cfg_wdata[6:0];
				REG_COLS_IN_USE: cfg_cols_q <= cfg_wdata[4:0];
				REG_LEVEL_COUNT: cfg_lvl_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (cfg_rows_q < 7'd2)
			nrows_c = NR_W'(2);
		else if (32'(cfg_rows_q) > MAX_ROWS)
			nrows_c = NR_W'(MAX_ROWS);
		else
			nrows_c = NR_W'(cfg_rows_q);
		if (cfg_cols_q < 5'd2)
			ncols_c = NC_W'(2);
		else if (32'(cfg_cols_q) > MAX_COLS)
			ncols_c = NC_W'(MAX_COLS);
		else
			ncols_c = NC_W'(cfg_cols_q);
	end

	// centering of a loaded level
	always_comb begin
		lc = (cfg_lvl_q < 8'd2) ? 8'd2 : cfg_lvl_q;
		if (in_data.level < 8'd1)
			lv = 8'd1;
		else if (in_data.level > lc)
			lv = lc;
		else
			lv = in_data.level;
		cval = {1'b0, lv, 1'b0} - {2'b00, lc} - 10'd1;
	end

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign load_we  = in_acc && (in_data.req_type == REQ_LOAD)
		&& (32'(in_data.row) < MAX_ROWS) && (32'(in_data.col) < MAX_COLS);
	assign waddr    = ADDR_W'(32'(in_data.row) * MAX_COLS + 32'(in_data.col));
	assign raddr_a  = ADDR_W'(32'(k_q) * MAX_COLS + 32'(i_q));
	assign raddr_b  = ADDR_W'(32'(k_q) * MAX_COLS + 32'(j_q));

	// design store
	always_ff @(posedge clk) begin
		if (load_we)
			dmem[waddr] <= CW'(cval);
		rd_a_s1 <= dmem[raddr_a];
		rd_b_s1 <= dmem[raddr_b];
	end

	// multiply-accumulate pipeline
	always_ff @(posedge clk) begin
		prod_s2 <= rd_a_s1 * rd_b_s1;
		if (state_q == S_CMP)
			acc_q <= '0;
		else if (in_acc)
			acc_q <= '0;
		else if (v_s2)
			acc_q <= acc_q + ACC_W'(prod_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (state_q == S_ISSUE);
			v_s2 <= v_s1;
		end
	end

	assign abs_v = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign mag   = (MW'(abs_v) > MW'(MAG_LIMIT)) ? 22'(MAG_LIMIT) : 22'(abs_v);

	// pair magnitude store
	always_ff @(posedge clk) begin
		if (state_q == S_CMP)
			mag_mem[slot_q] <= mag;
		mag_rd_q <= mag_mem[slot_q];
	end

	assign last_k    = (NR_W'(k_q) == nrows_q - NR_W'(1));
	assign last_pair = (NC_W'(i_q) == ncols_q - NC_W'(2));
	assign col_wrap  = (NC_W'(j_q) == ncols_q - NC_W'(1));
	assign hit       = (mag_rd_q == max_q);
	assign last_col  = (NC_W'(ocol_q) == ncols_q - NC_W'(1));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nrows_q <= NR_W'(2);
			ncols_q <= NC_W'(2);
			k_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			ocol_q  <= '0;
			slot_q  <= '0;
			max_q   <= '0;
			ties_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc && (in_data.req_type == REQ_EVAL)) begin
						nrows_q <= nrows_c;
						ncols_q <= ncols_c;
						k_q     <= '0;
						i_q     <= '0;
						j_q     <= COL_W'(1);
						slot_q  <= '0;
						max_q   <= '0;
						ties_q  <= '0;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					if (last_k)
						state_q <= S_DRAIN;
					else
						k_q <= k_q + K_W'(1);
				end
				S_DRAIN: begin
					if (!v_s1 && !v_s2)
						state_q <= S_CMP;
				end
				S_CMP: begin
					if (mag > max_q) begin
						max_q  <= mag;
						ties_q <= 7'd1;
					end else if (mag == max_q && 32'(ties_q) < TIE_LIMIT) begin
						ties_q <= ties_q + 7'd1;
					end
					k_q <= '0;
					if (last_pair) begin
						i_q     <= '0;
						j_q     <= COL_W'(1);
						slot_q  <= '0;
						state_q <= S_WRD;
					end else begin
						slot_q <= slot_q + SLOT_W'(1);
						if (col_wrap) begin
							i_q <= i_q + COL_W'(1);
							j_q <= i_q + COL_W'(2);
						end else begin
							j_q <= j_q + COL_W'(1);
						end
						state_q <= S_ISSUE;
					end
				end
				S_WRD: begin
					state_q <= S_WCHK;
				end
				S_WCHK: begin
					if (last_pair) begin
						ocol_q  <= '0;
						state_q <= S_EMIT;
					end else begin
						slot_q <= slot_q + SLOT_W'(1);
						if (col_wrap) begin
							i_q <= i_q + COL_W'(1);
							j_q <= i_q + COL_W'(2);
						end else begin
							j_q <= j_q + COL_W'(1);
						end
						state_q <= S_WRD;
					end
				end
				S_EMIT: begin
					if (out_ready) begin
						if (last_col)
							state_q <= S_IDLE;
						else
							ocol_q <= ocol_q + COL_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// column weights
	always_ff @(posedge clk) begin
		for (int c = 0; c < MAX_COLS; c++) begin
			if (state_q == S_CMP && last_pair)
				weight_q[c] <= 5'd1;
			else if (state_q == S_WCHK && hit
					&& (32'(i_q) == c || 32'(j_q) == c)
					&& 32'(weight_q[c]) < WEIGHT_LIMIT)
				weight_q[c] <= weight_q[c] + 5'd1;
		end
	end

	assign out_valid = (state_q == S_EMIT);
	always_comb begin
		out_data.column_index    = 4'(ocol_q);
		out_data.column_weight   = weight_q[ocol_q];
		out_data.max_abs_product = max_q;
		out_data.tie_count       = ties_q;
		out_data.last            = last_col;
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input and output sides active together");

	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (!v_s1 && !v_s2))
		else $error("pair closed with products still in flight");

	a_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $past(v_s1))
		else $error("product without a preceding read");

	a_weight_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.column_weight != 5'd0))
		else $error("column weight of zero");

	a_ties_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.tie_count != 7'd0))
		else $error("tie count of zero on a result");

endmodule
`default_nettype wire
